// File: rtl/core/blifo_pkg.sv
// ----------------------------------------------------------------------------
// blifo_pkg
// types, constants and codes shared by the bounded lifo stack modules
// ----------------------------------------------------------------------------
`default_nettype none

package blifo_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP  = 3'd4;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [WORD_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word_out;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic                     last_of_run;
  } res_t;

  typedef enum logic [1:0] {
    RD_TOP,
    RD_IDX,
    RD_NEXT
  } rd_sel_e;

  typedef struct packed {
    logic              cap;
    logic              wr_en;
    logic              cnt_dec;
    logic              cnt_clr;
    logic              rd_en;
    rd_sel_e           rd_sel;
    logic              idx_inc;
    logic              idx_clr;
    logic              emit;
    logic              emit_rd;
    logic [STAT_W-1:0] emit_status;
    logic              emit_last;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             cnt_zero;
    logic             cnt_full;
    logic             dump_last;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/blifo_dp.sv
// ----------------------------------------------------------------------------
// blifo_dp
// stack datapath: entry memory, fill count, dump index and result register
// ----------------------------------------------------------------------------
`default_nettype none

module blifo_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire blifo_pkg::cmd_t   cmd_i,
  input  wire blifo_pkg::ctrl_t  ctrl_i,
  output blifo_pkg::stat_t       stat_o,
  output logic                   result_valid_o,
  output blifo_pkg::res_t        result_o
);

  logic signed [blifo_pkg::WORD_W-1:0] mem [blifo_pkg::DEPTH];

  blifo_pkg::cmd_t                     cmd_q;
  logic [blifo_pkg::CNT_W-1:0]         count_q, count_d;
  logic [blifo_pkg::ADDR_W-1:0]        idx_q, idx_d;
  logic [blifo_pkg::ADDR_W-1:0]        rd_addr;
  logic signed [blifo_pkg::WORD_W-1:0] rd_data_q;
  logic                                valid_q;
  blifo_pkg::res_t                     res_q;
  logic [blifo_pkg::CNT_W-1:0]         idx_plus;

  assign idx_plus = blifo_pkg::CNT_W'(idx_q) + 1'b1;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.cnt_clr) begin
      count_d = '0;
    end else if (ctrl_i.wr_en) begin
      count_d = count_q + 1'b1;
    end else if (ctrl_i.cnt_dec) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (ctrl_i.idx_clr) begin
      idx_d = '0;
    end else if (ctrl_i.idx_inc) begin
      idx_d = blifo_pkg::ADDR_W'(idx_plus);
    end
  end

  always_comb begin
    case (ctrl_i.rd_sel)
      blifo_pkg::RD_TOP:  rd_addr = blifo_pkg::ADDR_W'(count_q - 1'b1);
      blifo_pkg::RD_IDX:  rd_addr = idx_q;
      blifo_pkg::RD_NEXT: rd_addr = blifo_pkg::ADDR_W'(idx_plus);
      default:            rd_addr = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      valid_q <= ctrl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      cmd_q <= cmd_i;
    end
    if (ctrl_i.emit) begin
      res_q.word_out    <= ctrl_i.emit_rd ? rd_data_q : '0;
      res_q.status      <= ctrl_i.emit_status;
      res_q.entry_count <= blifo_pkg::COUNT_W'(count_d);
      res_q.is_empty    <= (count_d == '0);
      res_q.last_of_run <= ctrl_i.emit_last;
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[count_q[blifo_pkg::ADDR_W-1:0]] <= cmd_q.push_value;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign stat_o.command   = cmd_q.command;
  assign stat_o.cnt_zero  = (count_q == '0);
  assign stat_o.cnt_full  = (count_q == blifo_pkg::CNT_W'(blifo_pkg::DEPTH));
  assign stat_o.dump_last = (idx_plus == count_q);

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= blifo_pkg::CNT_W'(blifo_pkg::DEPTH))
    else $error("fill count above depth");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.wr_en |-> !stat_o.cnt_full)
    else $error("write into full stack");

  a_no_read_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.rd_en && ctrl_i.rd_sel == blifo_pkg::RD_TOP) |-> !stat_o.cnt_zero)
    else $error("top read on empty stack");

  a_dump_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.rd_en && ctrl_i.rd_sel == blifo_pkg::RD_NEXT) |->
      (idx_plus < count_q))
    else $error("dump walk past top entry");

endmodule

`default_nettype wire

// File: rtl/core/blifo_ctrl.sv
// ----------------------------------------------------------------------------
// blifo_ctrl
// command sequencer for the bounded lifo stack
// ----------------------------------------------------------------------------
`default_nettype none

module blifo_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire blifo_pkg::stat_t  stat_i,
  output blifo_pkg::ctrl_t       ctrl_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d            = state_q;
    ctrl_o             = '0;
    ctrl_o.rd_sel      = blifo_pkg::RD_IDX;
    ctrl_o.emit_status = blifo_pkg::STATUS_OK;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctrl_o.cap = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        case (stat_i.command)
          blifo_pkg::CMD_PUSH: begin
            ctrl_o.emit      = 1'b1;
            ctrl_o.emit_last = 1'b1;
            if (stat_i.cnt_full) begin
              ctrl_o.emit_status = blifo_pkg::STATUS_FULL;
            end else begin
              ctrl_o.wr_en = 1'b1;
            end
          end
          blifo_pkg::CMD_POP, blifo_pkg::CMD_PEEK: begin
            if (stat_i.cnt_zero) begin
              ctrl_o.emit        = 1'b1;
              ctrl_o.emit_last   = 1'b1;
              ctrl_o.emit_status = blifo_pkg::STATUS_EMPTY;
            end else begin
              ctrl_o.rd_en   = 1'b1;
              ctrl_o.rd_sel  = blifo_pkg::RD_TOP;
              ctrl_o.cnt_dec = (stat_i.command == blifo_pkg::CMD_POP);
              state_d        = ST_OUT;
            end
          end
          blifo_pkg::CMD_CLEAR: begin
            ctrl_o.cnt_clr   = 1'b1;
            ctrl_o.emit      = 1'b1;
            ctrl_o.emit_last = 1'b1;
          end
          blifo_pkg::CMD_DUMP: begin
            if (stat_i.cnt_zero) begin
              ctrl_o.emit        = 1'b1;
              ctrl_o.emit_last   = 1'b1;
              ctrl_o.emit_status = blifo_pkg::STATUS_EMPTY;
            end else begin
              ctrl_o.rd_en  = 1'b1;
              ctrl_o.rd_sel = blifo_pkg::RD_IDX;
              state_d       = ST_OUT;
            end
          end
          default: begin
            ctrl_o.emit      = 1'b1;
            ctrl_o.emit_last = 1'b1;
          end
        endcase
      end
      ST_OUT: begin
        ctrl_o.emit    = 1'b1;
        ctrl_o.emit_rd = 1'b1;
        if (stat_i.command == blifo_pkg::CMD_DUMP && !stat_i.dump_last) begin
          ctrl_o.idx_inc = 1'b1;
          ctrl_o.rd_en   = 1'b1;
          ctrl_o.rd_sel  = blifo_pkg::RD_NEXT;
        end else begin
          ctrl_o.emit_last = 1'b1;
          ctrl_o.idx_clr   = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/bounded_lifo_stack.sv
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// bounded lifo stack of signed 32-bit words with push, pop, peek, clear, dump
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Each result is shown
// for exactly one cycle with result_valid_o high and must be captured then;
// results cannot be held off. Every command passes through the sequencer's
// decode step, where push, clear, unused codes and every error end; pop, peek
// and dump then go on to the output step, a dump giving one result per cycle,
// bottom entry first. The reads need that step because the read port of the
// entry memory is registered. The memory needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_lifo_stack (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire blifo_pkg::cmd_t  cmd_i,
  output logic                  result_valid_o,
  output blifo_pkg::res_t       result_o
);

  blifo_pkg::ctrl_t ctrl;
  blifo_pkg::stat_t stat;

  blifo_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  blifo_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the bounded lifo stack against a stack predictor kept in the bench
// ----------------------------------------------------------------------------
// Commands go in through the start/busy handshake in bursts with random gaps.
// Each accepted item updates the predicted stack and queues the results it
// should produce. A checker compares every result strobe field by field with
// the oldest queued result. Directed tests cover the empty and full stack, the
// word extremes and the unused command codes, then random traffic follows.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [blifo_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [blifo_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
  localparam logic signed [blifo_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [blifo_pkg::WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  blifo_pkg::cmd_t cmd_i;
  logic result_valid_o;
  blifo_pkg::res_t result_o;

  logic signed [blifo_pkg::WORD_W-1:0] stack_words [blifo_pkg::DEPTH];
  int unsigned                         stack_fill;
  blifo_pkg::res_t                     expected_stack_results [$];
  int unsigned                         mismatch_count;

  bounded_lifo_stack DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic void queue_result(blifo_pkg::res_t r);
    r.entry_count = blifo_pkg::COUNT_W'(stack_fill);
    r.is_empty    = (stack_fill == 0);
    expected_stack_results.push_back(r);
  endfunction

  function automatic void apply_stack_command(blifo_pkg::cmd_t item);
    blifo_pkg::res_t r;
    r             = '0;
    r.status      = blifo_pkg::STATUS_OK;
    r.last_of_run = 1'b1;
    case (item.command)
      blifo_pkg::CMD_PUSH: begin
        if (stack_fill >= blifo_pkg::DEPTH) begin
          r.status = blifo_pkg::STATUS_FULL;
        end else begin
          stack_words[stack_fill] = item.push_value;
          stack_fill++;
        end
      end
      blifo_pkg::CMD_POP: begin
        if (stack_fill == 0) begin
          r.status = blifo_pkg::STATUS_EMPTY;
        end else begin
          stack_fill--;
          r.word_out = stack_words[stack_fill];
        end
      end
      blifo_pkg::CMD_PEEK: begin
        if (stack_fill == 0) begin
          r.status = blifo_pkg::STATUS_EMPTY;
        end else begin
          r.word_out = stack_words[stack_fill-1];
        end
      end
      blifo_pkg::CMD_CLEAR: begin
        stack_fill = 0;
      end
      blifo_pkg::CMD_DUMP: begin
        if (stack_fill == 0) begin
          r.status = blifo_pkg::STATUS_EMPTY;
        end else begin
          for (int unsigned i = 0; i < stack_fill; i++) begin
            r.word_out    = stack_words[i];
            r.last_of_run = (i + 1 == stack_fill);
            queue_result(r);
          end
          return;
        end
      end
      default: ;
    endcase
    queue_result(r);
  endfunction

  function automatic logic signed [blifo_pkg::WORD_W-1:0] random_word();
    case ($urandom_range(0, 5))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return -1;
      3:       return $signed($urandom_range(0, 20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_field(input string field, input integer want, input integer got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatch_count++;
  endtask

  // result checker, sampled mid-cycle
  always @(negedge clk_i) begin
    blifo_pkg::res_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_stack_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, result_o);
        mismatch_count++;
      end else begin
        want = expected_stack_results.pop_front();
        if (result_o.word_out !== want.word_out)
          report_field("word_out", want.word_out, result_o.word_out);
        if (result_o.status !== want.status)
          report_field("status", want.status, result_o.status);
        if (result_o.entry_count !== want.entry_count)
          report_field("entry_count", want.entry_count, result_o.entry_count);
        if (result_o.is_empty !== want.is_empty)
          report_field("is_empty", want.is_empty, result_o.is_empty);
        if (result_o.last_of_run !== want.last_of_run)
          report_field("last_of_run", want.last_of_run, result_o.last_of_run);
      end
    end
  end

  task automatic send_command(input logic [blifo_pkg::CMD_W-1:0] code,
                              input logic signed [blifo_pkg::WORD_W-1:0] value);
    blifo_pkg::cmd_t item;
    logic was_busy;
    item.command    = code;
    item.push_value = value;
    start <= 1'b1;
    cmd_i <= item;
    forever begin
      @(negedge clk_i);
      was_busy = busy;
      @(posedge clk_i);
      if (!was_busy) break;
    end
    apply_stack_command(item);
  endtask

  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    cmd_i <= blifo_pkg::cmd_t'({blifo_pkg::CMD_W'($urandom), $urandom});
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (expected_stack_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_stack();
    send_command(blifo_pkg::CMD_POP, random_word());
    send_command(blifo_pkg::CMD_PEEK, random_word());
    send_command(blifo_pkg::CMD_DUMP, random_word());
    send_command(blifo_pkg::CMD_CLEAR, random_word());
    send_command(CMD_UNUSED_LO, random_word());
    send_command(CMD_UNUSED_HI, random_word());
    idle_cycles(3);
  endtask

  task automatic test_fill_and_overflow();
    send_command(blifo_pkg::CMD_PUSH, WORD_MIN);
    send_command(blifo_pkg::CMD_PUSH, WORD_MAX);
    send_command(blifo_pkg::CMD_PUSH, -1);
    send_command(blifo_pkg::CMD_PUSH, 0);
    send_command(blifo_pkg::CMD_PUSH, 1);
    while (stack_fill < blifo_pkg::DEPTH) send_command(blifo_pkg::CMD_PUSH, random_word());
    send_command(blifo_pkg::CMD_PUSH, random_word());
    send_command(blifo_pkg::CMD_PEEK, random_word());
    send_command(blifo_pkg::CMD_DUMP, random_word());
    idle_cycles(2);
  endtask

  task automatic test_pop_and_clear();
    send_command(blifo_pkg::CMD_POP, random_word());
    send_command(blifo_pkg::CMD_CLEAR, random_word());
    send_command(blifo_pkg::CMD_DUMP, random_word());
    idle_cycles(1);
  endtask

  task automatic test_drained_pause();
    send_command(blifo_pkg::CMD_PUSH, random_word());
    send_command(blifo_pkg::CMD_DUMP, random_word());
    wait_results_drained();
    send_command(blifo_pkg::CMD_PEEK, random_word());
    send_command(blifo_pkg::CMD_POP, random_word());
    idle_cycles(4);
  endtask

  task automatic test_random_traffic(input int unsigned item_total);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < item_total) begin
      repeat ($urandom_range(1, 12)) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          send_command(blifo_pkg::CMD_PUSH, random_word());
        end else if (pick < 63) begin
          send_command(blifo_pkg::CMD_POP, random_word());
        end else if (pick < 73) begin
          send_command(blifo_pkg::CMD_PEEK, random_word());
        end else if (pick < 82) begin
          send_command(blifo_pkg::CMD_DUMP, random_word());
        end else if (pick < 87) begin
          send_command(blifo_pkg::CMD_CLEAR, random_word());
        end else if (pick < 93) begin
          send_command(blifo_pkg::CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                       random_word());
        end else begin
          // run up to full, then one overflowing push
          while (stack_fill < blifo_pkg::DEPTH) begin
            send_command(blifo_pkg::CMD_PUSH, random_word());
            sent++;
          end
          send_command(blifo_pkg::CMD_PUSH, random_word());
        end
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 7));
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    cmd_i          = '0;
    stack_fill     = 0;
    mismatch_count = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_stack();
    test_fill_and_overflow();
    test_pop_and_clear();
    test_drained_pause();
    test_random_traffic(128);
    wait_results_drained();
    repeat (blifo_pkg::DEPTH + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule
